// ===== rtl/comment_stripping_tokenizer_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Comment stripping tokenizer: assertion macros
// Clocked property wrappers shared by the checker.
// ---------------------------------------------------------------------------
`ifndef COMMENT_STRIPPING_TOKENIZER_UNIT_MACROS_SVH
`define COMMENT_STRIPPING_TOKENIZER_UNIT_MACROS_SVH

// Property checked on clk_i, disabled while reset is asserted.
`define CST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on clk_i, also during reset.
`define CST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/cst_pkg.sv =====
// ---------------------------------------------------------------------------
// cst_pkg
// Shared types, byte codes and helpers of the comment stripping tokenizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cst_pkg;

  localparam int unsigned CST_MAX_TOKEN_LEN = 64;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       last;
    logic       overflow;
  } cst_result_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR);
  endfunction

endpackage

// ===== rtl/cst_in_if.sv =====
// ---------------------------------------------------------------------------
// cst_in_if
// Input channel: one raw text byte or an end-of-input marker per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== rtl/cst_out_if.sv =====
// ---------------------------------------------------------------------------
// cst_out_if
// Output channel: one token byte with last and overflow flags per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       last;
  logic       overflow;

  modport source (output valid, output token_byte, output last, output overflow,
                  input ready);
  modport sink   (input valid, input token_byte, input last, input overflow,
                  output ready);
endinterface

// ===== rtl/cst_lexer.sv =====
// ---------------------------------------------------------------------------
// cst_lexer
// Lexer state and combinational next-state logic; one byte per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cst_lexer import cst_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = CST_MAX_TOKEN_LEN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_input_i,
  output logic        res_valid_o,
  output cst_result_t res_o
);

  localparam int unsigned LenW = $clog2(MAX_TOKEN_LEN + 1);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BSTAR,
    MODE_TOKEN
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [7:0]       held_byte_q, held_byte_d;
  logic             held_valid_q, held_valid_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             exceeded_q, exceeded_d;

  logic blank, slash;

  assign blank = is_blank(in_byte_i);
  assign slash = (in_byte_i == CHAR_SLASH);

  always_comb begin
    mode_d       = mode_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    len_d        = len_q;
    exceeded_d   = exceeded_q;
    res_valid_o  = 1'b0;
    res_o        = '{token_byte: held_byte_q, last: 1'b0, overflow: 1'b0};

    if (end_of_input_i) begin
      if (mode_q == MODE_TOKEN && held_valid_q) begin
        res_valid_o = 1'b1;
        res_o.last     = 1'b1;
        res_o.overflow = exceeded_q;
      end
      mode_d       = MODE_IDLE;
      held_byte_d  = '0;
      held_valid_d = 1'b0;
      len_d        = '0;
      exceeded_d   = 1'b0;
    end else begin
      // slash not followed by a comment opener falls through to idle handling
      unique case (mode_q)
        MODE_LINE: begin
          if (in_byte_i == CHAR_LF || in_byte_i == CHAR_CR) mode_d = MODE_IDLE;
        end
        MODE_BLOCK: begin
          if (in_byte_i == CHAR_STAR) mode_d = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (slash) begin
            mode_d = MODE_IDLE;
          end else if (in_byte_i != CHAR_STAR) begin
            mode_d = MODE_BLOCK;
          end
        end
        MODE_TOKEN: begin
          if (blank || slash) begin
            if (held_valid_q) begin
              res_valid_o    = 1'b1;
              res_o.last     = 1'b1;
              res_o.overflow = exceeded_q;
            end
            held_byte_d  = '0;
            held_valid_d = 1'b0;
            len_d        = '0;
            exceeded_d   = 1'b0;
            mode_d       = slash ? MODE_SLASH : MODE_IDLE;
          end else if (len_q < LenW'(MAX_TOKEN_LEN)) begin
            res_valid_o  = held_valid_q;
            held_byte_d  = in_byte_i;
            held_valid_d = 1'b1;
            len_d        = len_q + LenW'(1);
          end else begin
            exceeded_d = 1'b1;
          end
        end
        default: begin
          if (mode_q == MODE_SLASH && slash) begin
            mode_d = MODE_LINE;
          end else if (mode_q == MODE_SLASH && in_byte_i == CHAR_STAR) begin
            mode_d = MODE_BLOCK;
          end else if (blank) begin
            mode_d = MODE_IDLE;
          end else if (slash) begin
            mode_d = MODE_SLASH;
          end else begin
            held_byte_d  = in_byte_i;
            held_valid_d = 1'b1;
            len_d        = LenW'(1);
            exceeded_d   = 1'b0;
            mode_d       = MODE_TOKEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      len_q        <= '0;
      exceeded_q   <= 1'b0;
    end else if (step_i) begin
      mode_q       <= mode_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      len_q        <= len_d;
      exceeded_q   <= exceeded_d;
    end
  end

endmodule

// ===== rtl/cst_out_reg.sv =====
// ---------------------------------------------------------------------------
// cst_out_reg
// Result register between the lexer and the output channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cst_out_reg import cst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  cst_result_t res_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output cst_result_t out_res_o,
  output logic        free_o
);

  logic        valid_q;
  cst_result_t res_q;

  // free when empty or when the held result transfers this cycle
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/comment_stripping_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// comment_stripping_tokenizer_unit
// Strips blanks and C comments from a byte stream and emits token bytes.
// ---------------------------------------------------------------------------
// One input byte is taken per cycle while the input is ready, and each transfer
// yields at most one token byte, delivered from the result register in the cycle
// after its input transfer. The input is ready whenever the result register is
// empty or its result transfers in the same cycle, so throughput is one byte per
// cycle as long as the output side keeps up. The last byte of each token carries
// last, and overflow when bytes past MAX_TOKEN_LEN were dropped.
`timescale 1ns / 1ps

module comment_stripping_tokenizer_unit import cst_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = CST_MAX_TOKEN_LEN
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cst_in_if.sink   in_i,
  cst_out_if.source out_o
);

  logic        step;
  logic        res_valid;
  cst_result_t res;
  logic        free;
  cst_result_t out_res;

  assign in_i.ready = free;
  assign step       = in_i.valid && free;

  cst_lexer #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_lexer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .in_byte_i      (in_i.in_byte),
    .end_of_input_i (in_i.end_of_input),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  cst_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_res_o   (out_res),
    .free_o      (free)
  );

  assign out_o.token_byte = out_res.token_byte;
  assign out_o.last       = out_res.last;
  assign out_o.overflow   = out_res.overflow;

endmodule

// ===== rtl/cst_checker.sv =====
// ---------------------------------------------------------------------------
// cst_checker
// Port-level assertions for the comment stripping tokenizer, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "comment_stripping_tokenizer_unit_macros.svh"

module cst_checker import cst_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] token_byte_i,
  input logic       last_i,
  input logic       overflow_i
);

  logic       bad_byte;
  logic       out_stall;
  logic [9:0] res_bits;

  assign bad_byte  = is_blank(token_byte_i) || (token_byte_i == CHAR_SLASH);
  assign out_stall = out_valid_i && !out_ready_i;
  assign res_bits  = {token_byte_i, last_i, overflow_i};

  `CST_ASSERT(a_ovf_on_last, (out_valid_i && overflow_i) |-> last_i, "overflow without last")
  `CST_ASSERT(a_no_blank_out, out_valid_i |-> !bad_byte, "blank or slash emitted")
  `CST_ASSERT(a_ready_when_empty, !out_valid_i |-> in_ready_i, "input stalled with empty output")
  `CST_ASSERT(a_out_hold, out_stall |=> (out_valid_i && $stable(res_bits)), "stalled result lost")

endmodule

bind comment_stripping_tokenizer_unit cst_checker u_cst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .token_byte_i (out_o.token_byte),
  .last_i       (out_o.last),
  .overflow_i   (out_o.overflow)
);
